// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is active.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Clocked implication check.
`define ASSERT_IMPL(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

`endif

// ----- rtl/idr_pkg.sv -----
// Package for the indexed deque ring: sizes, command and status codes, control structs.
package idr_pkg;

	localparam int DEPTH      = 256;
	localparam int DATA_WIDTH = 32;
	localparam int ADDR_W     = $clog2(DEPTH);
	localparam int CNT_W      = ADDR_W + 1;

	localparam int CMD_W  = 3;
	localparam int POS_W  = 8;
	localparam int VAL_W  = 32;
	localparam int RD_W   = 32;
	localparam int STAT_W = 2;
	localparam int OCC_W  = 9;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_BACK   = 3'd0,
		CMD_PUSH_FRONT  = 3'd1,
		CMD_READ_INDEX  = 3'd2,
		CMD_WRITE_INDEX = 3'd3,
		CMD_READ_FRONT  = 3'd4,
		CMD_READ_BACK   = 3'd5,
		CMD_WRITE_FRONT = 3'd6,
		CMD_WRITE_BACK  = 3'd7
	} cmd_e_t;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	// Controller to datapath.
	typedef struct packed {
		logic latch_in;   // capture the input transaction
		logic exec;       // check bounds, access the ring, update pointers
		logic load_out;   // move the result into the output register
	} dp_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic out_free;   // output register empty or being drained this cycle
	} dp_stat_t;

endpackage

// ----- rtl/indexed_deque_ring.sv -----
// Indexed deque ring: a 256 x 32 double-ended queue with random access by logical index,
// held in a ring RAM with a head pointer and an element count. Each input transaction
// (push back/front, read/write by index, read/write front/back) yields one result with
// read data, status (ok, out of range or empty, full) and the count after the command.
// After the accepting edge, the execute step does the RAM access with bounds check and pointer
// update, then the capture step loads the registered RAM read data into the output register
// once it is free. The sequencer takes no new transaction until it is back in its idle step;
// the input is then taken again even while the previous result still waits in the output
// register. No clearing pass.
`include "assert_macros.svh"

module indexed_deque_ring (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [idr_pkg::CMD_W-1:0]   command,
	input  logic [idr_pkg::POS_W-1:0]   position,
	input  logic [idr_pkg::VAL_W-1:0]   value,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [idr_pkg::RD_W-1:0]    read_data,
	output logic [idr_pkg::STAT_W-1:0]  status,
	output logic [idr_pkg::OCC_W-1:0]   occupancy
);
	import idr_pkg::*;

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	idr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (dp_stat),
		.cmd      (dp_cmd)
	);

	idr_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (dp_cmd),
		.stat      (dp_stat),
		.command   (command),
		.position  (position),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.read_data (read_data),
		.status    (status),
		.occupancy (occupancy)
	);

	`ASSERT_IMPL(a_occ_bound, out_valid, occupancy <= OCC_W'(DEPTH), "occupancy above depth")
	`ASSERT_IMPL(a_full_occ, out_valid && (status == ST_FULL), occupancy == OCC_W'(DEPTH),
		"full status with free space")
	`ASSERT_IMPL(a_err_zero, out_valid && (status != ST_OK), read_data == '0,
		"nonzero read data on error")
	`ASSERT_CLK(a_status_code, !out_valid || (status != 2'd3), "undefined status code")

endmodule

// ----- rtl/idr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module idr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/idr_ctrl.sv -----
// Sequencer for the indexed deque ring: accept, execute, load result.
module idr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  idr_pkg::dp_stat_t stat,
	output idr_pkg::dp_cmd_t  cmd
);
	import idr_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_CAPT = 3'b100
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d      = state_q;
		in_ready     = 1'b0;
		cmd.latch_in = 1'b0;
		cmd.exec     = 1'b0;
		cmd.load_out = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready     = 1'b1;
				cmd.latch_in = in_valid;
				if (in_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = S_CAPT;
			end
			S_CAPT: begin
				// RAM read data holds until the output slot frees up
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- rtl/idr_dp.sv -----
// Datapath of the indexed deque ring: pointers, bounds checks, ring RAM, output register.
module idr_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  idr_pkg::dp_cmd_t             cmd,
	output idr_pkg::dp_stat_t            stat,
	input  logic [idr_pkg::CMD_W-1:0]    command,
	input  logic [idr_pkg::POS_W-1:0]    position,
	input  logic [idr_pkg::VAL_W-1:0]    value,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [idr_pkg::RD_W-1:0]     read_data,
	output logic [idr_pkg::STAT_W-1:0]   status,
	output logic [idr_pkg::OCC_W-1:0]    occupancy
);
	import idr_pkg::*;

	cmd_e_t                cmd_q;
	logic [POS_W-1:0]      pos_q;
	logic [DATA_WIDTH-1:0] val_q;
	logic [ADDR_W-1:0]     head_q;
	logic [CNT_W-1:0]      count_q;
	logic [STAT_W-1:0]     st_q;
	logic                  rd_ok_q;
	logic                  out_valid_q;
	logic [RD_W-1:0]       read_data_q;
	logic [STAT_W-1:0]     status_q;
	logic [OCC_W-1:0]      occupancy_q;

	logic                  is_push, is_read, full, empty, in_range;
	logic [STAT_W-1:0]     st_d;
	logic [ADDR_W-1:0]     offset, addr;
	logic                  ram_we, ram_re;
	logic [DATA_WIDTH-1:0] ram_rdata;

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			cmd_q <= cmd_e_t'(command);
			pos_q <= position;
			val_q <= DATA_WIDTH'(value);
		end
	end

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign in_range = ({{(CNT_W > POS_W ? CNT_W - POS_W : 0){1'b0}}, pos_q} < count_q);

	always_comb begin
		is_push = 1'b0;
		is_read = 1'b0;
		st_d    = ST_OK;
		offset  = '0;
		case (cmd_q)
			CMD_PUSH_BACK: begin
				is_push = 1'b1;
				offset  = count_q[ADDR_W-1:0];
				if (full) st_d = ST_FULL;
			end
			CMD_PUSH_FRONT: begin
				is_push = 1'b1;
				offset  = '1;   // head - 1 mod DEPTH
				if (full) st_d = ST_FULL;
			end
			CMD_READ_INDEX, CMD_WRITE_INDEX: begin
				is_read = (cmd_q == CMD_READ_INDEX);
				offset  = ADDR_W'(pos_q);
				if (!in_range) st_d = ST_RANGE;
			end
			CMD_READ_FRONT, CMD_WRITE_FRONT: begin
				is_read = (cmd_q == CMD_READ_FRONT);
				offset  = '0;
				if (empty) st_d = ST_RANGE;
			end
			CMD_READ_BACK, CMD_WRITE_BACK: begin
				is_read = (cmd_q == CMD_READ_BACK);
				offset  = ADDR_W'(count_q - CNT_W'(1));
				if (empty) st_d = ST_RANGE;
			end
			default: begin
				st_d = ST_RANGE;
			end
		endcase
	end

	assign addr   = head_q + offset;
	assign ram_we = cmd.exec && (st_d == ST_OK) && !is_read;
	assign ram_re = cmd.exec && (st_d == ST_OK) && is_read;

	idr_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr),
		.wdata (val_q),
		.re    (ram_re),
		.raddr (addr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (cmd.exec && is_push && (st_d == ST_OK)) begin
			count_q <= count_q + CNT_W'(1);
			if (cmd_q == CMD_PUSH_FRONT) begin
				head_q <= addr;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			st_q    <= st_d;
			rd_ok_q <= is_read && (st_d == ST_OK);
		end
	end

	// Output register; count_q already reflects the finished transaction here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			read_data_q <= rd_ok_q ? RD_W'(ram_rdata) : '0;
			status_q    <= st_q;
			occupancy_q <= OCC_W'(count_q);
		end
	end

	assign stat.out_free = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign read_data     = read_data_q;
	assign status        = status_q;
	assign occupancy     = occupancy_q;

endmodule
